// ===== sv/rwbvp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwbvp_pkg
// Shared types and constants of the register write batch varint packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rwbvp_pkg;

    localparam int BATCH_DEPTH_DEF = 8;   // buffered writes per batch
    localparam int QUEUE_DEPTH     = 2;   // command queue between front and back

    localparam int VAL_W   = 32;          // widest value sent as a varint
    localparam int GROUP_W = 7;           // payload bits per encoded byte
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;

    // one classified command handed from front to back
    typedef struct packed {
        logic              is_flush;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [VAL_W-1:0]  samples;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/rwbvp_front.sv =====
// ----------------------------------------------------------------------------
// rwbvp_front
// Input stage: takes stream items, turns them into commands and drops
// delays of zero samples.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbvp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tvalid,
    output logic                    o_tready,
    input  wire logic               i_req_type,
    input  wire logic [7:0]         i_reg_addr,
    input  wire logic [7:0]         i_reg_value,
    input  wire logic [31:0]        i_wait_samples,
    output logic                    o_cmd_valid,
    input  wire logic               i_cmd_ready,
    output rwbvp_pkg::t_cmd         o_cmd
);

    logic            r_valid;
    rwbvp_pkg::t_cmd r_cmd;
    logic            take;
    logic            keep;

    assign o_tready    = !r_valid || i_cmd_ready;
    assign take        = i_tvalid && o_tready;
    // a zero delay changes nothing downstream
    assign keep        = !i_req_type || (i_wait_samples != '0);
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.is_flush <= i_req_type;
            r_cmd.addr     <= i_reg_addr;
            r_cmd.data     <= i_reg_value;
            r_cmd.samples  <= i_wait_samples;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rwbvp_queue.sv =====
// ----------------------------------------------------------------------------
// rwbvp_queue
// Short command queue that decouples the input stage from the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbvp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_ready,
    input  wire rwbvp_pkg::t_cmd    i_cmd,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output rwbvp_pkg::t_cmd         o_cmd
);

    localparam int DEPTH = rwbvp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rwbvp_pkg::t_cmd  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_level;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_level != CNT_W'(DEPTH));
    assign o_valid = (r_level != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/rwbvp_back.sv =====
// ----------------------------------------------------------------------------
// rwbvp_back
// Packer: buffers register writes and, on a flush, serializes count, writes
// and sample count as 7-bit little-endian varints, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbvp_back #(
    parameter int BATCH_DEPTH = rwbvp_pkg::BATCH_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_pop,
    input  wire rwbvp_pkg::t_cmd    i_cmd,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [7:0]              o_out_byte,
    output logic                    o_last,
    output logic                    o_overflow
);

    localparam int CNT_W   = $clog2(BATCH_DEPTH + 1);
    localparam int IDX_W   = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
    localparam int VAL_W   = rwbvp_pkg::VAL_W;
    localparam int GROUP_W = rwbvp_pkg::GROUP_W;
    localparam int ENT_W   = rwbvp_pkg::ADDR_W + rwbvp_pkg::DATA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;   // lets the first entry read settle
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [1:0] SEL_COUNT = 2'd0;
    localparam logic [1:0] SEL_ADDR  = 2'd1;
    localparam logic [1:0] SEL_DATA  = 2'd2;
    localparam logic [1:0] SEL_SAMP  = 2'd3;

    logic [ENT_W-1:0]   r_mem [BATCH_DEPTH];
    logic [ENT_W-1:0]   r_rd_data;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_sel, n_sel;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [VAL_W-1:0]   r_samples, n_samples;
    logic [7:0]         r_hold, n_hold;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_ovf, n_ovf;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               wr_en;
    logic               load;
    logic               fin;
    logic [VAL_W-1:0]   rest;

    assign rest = r_val >> GROUP_W;
    assign fin  = (rest == '0);
    assign load = (r_state == S_EMIT) && (!r_out_valid || i_tready);

    assign o_tvalid   = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_cmd.addr, i_cmd.data};
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_val     = r_val;
        n_samples = r_samples;
        n_hold    = r_hold;
        n_count   = r_count;
        n_left    = r_left;
        n_idx     = r_idx;
        n_ovf     = r_ovf;
        wr_en     = 1'b0;
        o_cmd_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_flush) begin
                        if (r_count < CNT_W'(BATCH_DEPTH)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_samples = i_cmd.samples;
                        n_val     = VAL_W'(r_count);
                        n_left    = r_count;
                        n_sel     = SEL_COUNT;
                        n_state   = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load) begin
                    if (!fin) begin
                        n_val = rest;
                    end else begin
                        case (r_sel)
                            SEL_COUNT: begin
                                if (r_left == '0) begin
                                    n_sel = SEL_SAMP;
                                    n_val = r_samples;
                                end else begin
                                    n_sel  = SEL_ADDR;
                                    n_val  = VAL_W'(r_rd_data[ENT_W-1:rwbvp_pkg::DATA_W]);
                                    n_hold = r_rd_data[rwbvp_pkg::DATA_W-1:0];
                                    if (r_left > CNT_W'(1)) begin
                                        n_idx = r_idx + 1'b1;
                                    end
                                end
                            end
                            SEL_ADDR: begin
                                n_sel = SEL_DATA;
                                n_val = VAL_W'(r_hold);
                            end
                            SEL_DATA: begin
                                n_left = r_left - 1'b1;
                                if (r_left == CNT_W'(1)) begin
                                    n_sel = SEL_SAMP;
                                    n_val = r_samples;
                                end else begin
                                    n_sel  = SEL_ADDR;
                                    n_val  = VAL_W'(r_rd_data[ENT_W-1:rwbvp_pkg::DATA_W]);
                                    n_hold = r_rd_data[rwbvp_pkg::DATA_W-1:0];
                                    if (r_left > CNT_W'(2)) begin
                                        n_idx = r_idx + 1'b1;
                                    end
                                end
                            end
                            SEL_SAMP: begin
                                n_state = S_IDLE;
                                n_count = '0;
                                n_idx   = '0;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= SEL_COUNT;
            r_count   <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_ovf <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_count <= n_count;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            if (load) begin
                r_out_valid <= 1'b1;
                r_out_ovf   <= r_ovf;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_samples <= n_samples;
        r_hold    <= n_hold;
        if (load) begin
            r_out_byte <= {fin, r_val[GROUP_W-1:0]};
            r_out_last <= fin && (r_sel == SEL_SAMP);
        end
    end

endmodule

`default_nettype wire

// ===== sv/register_write_batch_varint_packer.sv =====
// ----------------------------------------------------------------------------
// register_write_batch_varint_packer
// Batches register writes and packs each batch as a varint byte burst.
// ----------------------------------------------------------------------------
// A write item is stored in the batch buffer at the edge where it leaves the
// command queue; a write into a full buffer is dropped and sets the sticky
// overflow flag (tuser on the output). A delay item with a nonzero sample
// count sends the burst: write count, address and data of each write (oldest
// first), then the sample count, each as 7-bit groups with the low group
// first and bit 7 set on a value's final byte; tlast marks the final byte.
// A burst leaves one byte per cycle out of the output register while the
// receiver does not stall. A zero delay is discarded at the input.
// The input stays open while a burst is sent until the two-entry command
// queue and the input register are full.
`default_nettype none

module register_write_batch_varint_packer #(
    parameter int BATCH_DEPTH = rwbvp_pkg::BATCH_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // reg_addr, reg_value, wait_samples
    input  wire logic        i_s_axis_tuser,   // req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tuser    // overflow
);

    logic            front_valid;
    logic            queue_ready;
    rwbvp_pkg::t_cmd front_cmd;
    logic            queue_valid;
    logic            queue_pop;
    rwbvp_pkg::t_cmd queue_cmd;

    rwbvp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tvalid       (i_s_axis_tvalid),
        .o_tready       (o_s_axis_tready),
        .i_req_type     (i_s_axis_tuser),
        .i_reg_addr     (i_s_axis_tdata[7:0]),
        .i_reg_value    (i_s_axis_tdata[15:8]),
        .i_wait_samples (i_s_axis_tdata[47:16]),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (queue_ready),
        .o_cmd          (front_cmd)
    );

    rwbvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd)
    );

    rwbvp_back #(
        .BATCH_DEPTH (BATCH_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_pop   (queue_pop),
        .i_cmd       (queue_cmd),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_out_byte  (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_overflow  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/rwbvp_checker.sv =====
// ----------------------------------------------------------------------------
// rwbvp_checker
// Port-level checks of the packer's output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbvp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [7:0]  o_m_axis_tdata,
    input wire logic        o_m_axis_tlast,
    input wire logic        o_m_axis_tuser
);

    // a stalled output transfer keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output byte changed while stalled");

    // end of burst is always the final byte of a value
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[7])
        else $error("tlast on a non-final varint byte");

    // overflow flag is sticky until reset
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_m_axis_tuser) |-> o_m_axis_tuser)
        else $error("overflow flag cleared");

    // the byte after a burst end starts a count value; a count fits one byte
    a_count_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast ##1 o_m_axis_tvalid
        |-> o_m_axis_tdata[7])
        else $error("burst count not a single byte");

endmodule

bind register_write_batch_varint_packer rwbvp_checker u_rwbvp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== tb/register_write_batch_varint_packer_tb.sv =====
// ----------------------------------------------------------------------------
// register_write_batch_varint_packer_tb
// Self-checking bench: register write batches in, varint byte bursts out.
// ----------------------------------------------------------------------------
// A scoreboard class tracks the pending write batch and the sticky overflow
// flag. It turns every accepted input transfer into the bytes the burst must
// carry, and compares each output transfer against the oldest of them. The
// stimulus starts with directed corner cases. Random batches follow, first
// without a drop and then with an overflow phase. Both stream sides stall
// at random, and the receiver holds off once for a long stretch.
`timescale 1ns / 1ps

typedef struct {
    logic [7:0] code;
    logic       tl;
    logic       ovf;
} t_burst_byte;

class burst_scoreboard;
    logic [15:0] held_writes[$];
    logic        ovf_sticky;
    t_burst_byte byte_q[$];
    int          errors;

    function new();
        ovf_sticky = 1'b0;
        errors     = 0;
    endfunction

    function void push_varint(logic [31:0] v);
        t_burst_byte b;
        do begin
            b.code = {1'b0, v[6:0]};
            v      = v >> 7;
            if (v == 32'd0) b.code[7] = 1'b1;
            b.tl  = 1'b0;
            b.ovf = ovf_sticky;
            byte_q.insert(byte_q.size(), b);
        end while (v != 32'd0);
    endfunction

    function void note_input(logic kind, logic [7:0] addr, logic [7:0] data,
                             logic [31:0] samples);
        if (kind == 1'b0) begin
            if (held_writes.size() < rwbvp_pkg::BATCH_DEPTH_DEF)
                held_writes.insert(held_writes.size(), {addr, data});
            else
                ovf_sticky = 1'b1;
        end else if (samples != 32'd0) begin
            push_varint(32'(held_writes.size()));
            foreach (held_writes[i]) begin
                push_varint({24'd0, held_writes[i][15:8]});
                push_varint({24'd0, held_writes[i][7:0]});
            end
            push_varint(samples);
            byte_q[byte_q.size()-1].tl = 1'b1;
            held_writes.delete();
        end
    endfunction

    function void check_result(logic [7:0] code, logic tl, logic ovf);
        t_burst_byte want;
        if (byte_q.size() == 0) begin
            $display("%0t: unexpected byte %h (tlast %b tuser %b)", $time, code, tl, ovf);
            errors++;
            return;
        end
        want = byte_q.pop_front();
        if (code !== want.code) begin
            $display("%0t: byte expected %h actual %h", $time, want.code, code);
            errors++;
        end
        if (tl !== want.tl) begin
            $display("%0t: tlast expected %b actual %b", $time, want.tl, tl);
            errors++;
        end
        if (ovf !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
            errors++;
        end
    endfunction

    function int pending();
        return byte_q.size();
    endfunction
endclass

module register_write_batch_varint_packer_tb;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DELAY = 1'b1;
    localparam int   HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // reg_addr, reg_value, wait_samples
    logic        i_s_axis_tuser = 1'b0; // req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // out_byte
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;        // overflow

    burst_scoreboard sb = new();

    int   items_sent = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    register_write_batch_varint_packer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: checks each output transfer, then picks tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    task automatic send_item(logic kind, logic [7:0] addr, logic [7:0] data,
                             logic [31:0] samples);
        while (!calm && $urandom_range(99) < 27) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {samples, data, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(kind, addr, data, samples);
        items_sent++;
    endtask

    task automatic send_write(logic [7:0] addr, logic [7:0] data);
        send_item(REQ_WRITE, addr, data, $urandom);
    endtask

    task automatic send_delay(logic [31:0] samples);
        send_item(REQ_DELAY, 8'($urandom), 8'($urandom), samples);
    endtask

    function automatic logic [31:0] rand_samples();
        logic [31:0] v;
        int          w;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(1, 127);
            1: v = $urandom_range(128, 16383);
            2: begin
                w = $urandom_range(1, 32);
                v = $urandom;
                if (w < 32) v = v & ((32'h1 << w) - 1);
            end
            3: v = {1'b1, 31'($urandom)};
            default: v = $urandom;
        endcase
        if (v == 32'd0) v = 32'd1;
        return v;
    endfunction

    // writes with random content closed by a nonzero delay; stray zero delays as noise
    task automatic run_batch(int max_writes);
        int n;
        n = $urandom_range(0, max_writes);
        calm <= (items_sent >= 150 && items_sent < 200);
        if (items_sent >= 60) hold_req <= 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_delay(32'd0);
            send_write(8'($urandom), 8'($urandom));
        end
        send_delay(rand_samples());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty batch, smallest count
        send_delay(32'd1);
        // address and data extremes, one-byte sample count
        send_write(8'hff, 8'hff);
        send_write(8'h00, 8'h00);
        send_delay(32'h7f);
        // group boundary values, zero delay keeps the batch
        send_write(8'h7f, 8'h80);
        send_delay(32'd0);
        send_write(8'h80, 8'h7f);
        send_delay(32'h80);
        // full batch, widest sample count
        for (int i = 0; i < rwbvp_pkg::BATCH_DEPTH_DEF; i++)
            send_write(8'($urandom), 8'($urandom));
        send_delay(32'hffff_ffff);

        while (items_sent < 220) run_batch(rwbvp_pkg::BATCH_DEPTH_DEF);

        // writes into a full batch are dropped, flag stays set afterwards
        for (int i = 0; i < rwbvp_pkg::BATCH_DEPTH_DEF + 2; i++)
            send_write(8'($urandom), 8'($urandom));
        send_delay(rand_samples());
        send_delay(32'd1);

        while (items_sent < 325) run_batch(rwbvp_pkg::BATCH_DEPTH_DEF + 2);

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
